// ===== sv/double_ended_queue_macros.svh =====
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Concurrent check that is switched off while reset is applied.
`define DEQ_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Types and constants shared by the double-ended queue controller and datapath.
package deq_pkg;

  localparam int DATA_W = 32;

  // Command codes carried by the action field.
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Source of the ring store read address.
  typedef enum logic [1:0] {
    RD_FRONT = 2'd0,
    RD_REAR  = 2'd1,
    RD_WALK  = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_cmd;
    logic    wr_en;
    logic    wr_front;
    logic    front_dec;
    logic    front_inc;
    logic    count_inc;
    logic    count_dec;
    rd_sel_t rd_sel;
    logic    walk_init;
    logic    walk_step;
    logic    emit;
    logic    emit_data;
    logic    emit_last;
    status_t emit_status;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] action;
    logic       full;
    logic       empty;
    logic       walk_last;
  } stat_t;

endpackage

// ===== sv/deq_ctrl.sv =====
// Controller state machine of the double-ended queue.
module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     action,
  input  deq_pkg::stat_t stat,
  output deq_pkg::ctrl_t ctrl,
  output logic           busy
);
  import deq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    ctrl             = '0;
    ctrl.rd_sel      = RD_FRONT;
    ctrl.emit_status = ST_OK;
    case (state)
      S_IDLE: begin
        // Unused action codes are taken and dropped without a result.
        if (start && (action inside {ACT_PUSH_FRONT, ACT_PUSH_REAR, ACT_POP_FRONT,
                                     ACT_POP_REAR, ACT_LIST})) begin
          ctrl.load_cmd = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (stat.action)
          ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
            ctrl.emit      = 1'b1;
            ctrl.emit_last = 1'b1;
            if (stat.full) begin
              ctrl.emit_status = ST_FULL;
            end else begin
              ctrl.wr_en     = 1'b1;
              ctrl.wr_front  = (stat.action == ACT_PUSH_FRONT);
              ctrl.front_dec = (stat.action == ACT_PUSH_FRONT);
              ctrl.count_inc = 1'b1;
            end
          end
          ACT_POP_FRONT, ACT_POP_REAR: begin
            if (stat.empty) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_last   = 1'b1;
              ctrl.emit_status = ST_UNDERFLOW;
            end else begin
              ctrl.rd_sel    = (stat.action == ACT_POP_FRONT) ? RD_FRONT : RD_REAR;
              ctrl.front_inc = (stat.action == ACT_POP_FRONT);
              ctrl.count_dec = 1'b1;
              state_next     = S_POP;
            end
          end
          ACT_LIST: begin
            if (stat.empty) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_last   = 1'b1;
              ctrl.emit_status = ST_EMPTY;
            end else begin
              ctrl.rd_sel    = RD_FRONT;
              ctrl.walk_init = 1'b1;
              state_next     = S_LIST;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        // The popped word arrives from the store read register.
        ctrl.emit      = 1'b1;
        ctrl.emit_data = 1'b1;
        ctrl.emit_last = 1'b1;
        state_next     = S_IDLE;
      end
      S_LIST: begin
        // Emit the word read last cycle and fetch the following slot.
        ctrl.emit      = 1'b1;
        ctrl.emit_data = 1'b1;
        ctrl.emit_last = stat.walk_last;
        ctrl.rd_sel    = RD_WALK;
        ctrl.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/deq_dp.sv =====
// Datapath of the double-ended queue: ring store, pointers and result register.
module deq_dp #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [2:0]                          action,
  input  logic signed [deq_pkg::DATA_W-1:0]   value,
  input  deq_pkg::ctrl_t                      ctrl,
  output deq_pkg::stat_t                      stat,
  output logic                                strobe,
  output logic signed [deq_pkg::DATA_W-1:0]   value_res,
  output logic [1:0]                          status,
  output logic                                last
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  logic [2:0]               cmd_action;
  logic signed [DATA_W-1:0] cmd_value;
  logic [IW-1:0]            front;
  logic [CW-1:0]            count;
  logic [IW-1:0]            walk;
  logic [CW-1:0]            offset;
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [SW-1:0]            tail_sum;
  logic [IW-1:0]            tail;
  logic [IW-1:0]            rear;
  logic [IW-1:0]            wr_addr;
  logic [IW-1:0]            rd_addr;

  // Ring increment and decrement over DEPTH slots.
  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
    ring_inc = (x == IW'(DEPTH - 1)) ? '0 : x + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] x);
    ring_dec = (x == '0) ? IW'(DEPTH - 1) : x - IW'(1);
  endfunction

  // Slot after the rear entry, and the rear entry itself.
  always_comb begin
    tail_sum = SW'(front) + SW'(count);
    if (tail_sum >= SW'(DEPTH)) begin
      tail = IW'(tail_sum - SW'(DEPTH));
    end else begin
      tail = IW'(tail_sum);
    end
    rear = ring_dec(tail);
  end

  // Store addresses.
  assign wr_addr = ctrl.wr_front ? ring_dec(front) : tail;

  always_comb begin
    case (ctrl.rd_sel)
      RD_FRONT: rd_addr = front;
      RD_REAR:  rd_addr = rear;
      RD_WALK:  rd_addr = walk;
      default:  rd_addr = front;
    endcase
  end

  // Command register, loaded on each accepted transfer that carries a used action code.
  always_ff @(posedge clk) begin
    if (ctrl.load_cmd) begin
      cmd_action <= action;
      cmd_value  <= value;
    end
  end

  // Front index and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (ctrl.front_dec) begin
        front <= ring_dec(front);
      end else if (ctrl.front_inc) begin
        front <= ring_inc(front);
      end
      if (ctrl.count_inc) begin
        count <= count + CW'(1);
      end else if (ctrl.count_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  // Listing walk pointer and the number of entries already emitted.
  always_ff @(posedge clk) begin
    if (ctrl.walk_init) begin
      walk   <= ring_inc(front);
      offset <= '0;
    end else if (ctrl.walk_step) begin
      walk   <= ring_inc(walk);
      offset <= offset + CW'(1);
    end
  end

  // Ring store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= cmd_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Result register; the strobe marks the single cycle of each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      value_res <= ctrl.emit_data ? rd_data : '0;
      status    <= ctrl.emit_status;
      last      <= ctrl.emit_last;
    end
  end

  // Status towards the controller.
  assign stat.action    = cmd_action;
  assign stat.full      = (count >= CW'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.walk_last = (offset == count - CW'(1));

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of 32-bit signed words.
//
//   Channel   Handshake         Payload                    Direction
//   command   start / busy      action, value              in
//   result    strobe            value_res, status, last    out
//
// A command transfer takes place when start is high and busy is low.
// Push: the execute state alone. Pop: the execute state, then the pop state for
// the registered read of the ring store. List: the execute state, then the list
// state, one entry and one store read per cycle. Unused action codes are dropped.
// Each result is registered, shown the cycle after it is issued, for one cycle.
// rst is synchronous and empties the queue; the receiver cannot stall.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        action,
  input  logic signed [deq_pkg::DATA_W-1:0] value,
  output logic                              strobe,
  output logic signed [deq_pkg::DATA_W-1:0] value_res,
  output logic [1:0]                        status,
  output logic                              last
);
  import deq_pkg::*;

  `include "double_ended_queue_macros.svh"

  ctrl_t ctrl;
  stat_t stat;

  // Controller.
  deq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Datapath.
  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .value     (value),
    .ctrl      (ctrl),
    .stat      (stat),
    .strobe    (strobe),
    .value_res (value_res),
    .status    (status),
    .last      (last)
  );

  // A result only follows a cycle in which a command was being worked on.
  `DEQ_ASSERT_RST(a_strobe_after_busy, clk, rst, strobe |-> $past(busy), "result without command")
  // A valid command transfer always makes the block busy.
  `DEQ_ASSERT_RST(a_accept_busy, clk, rst, (start && !busy && action <= ACT_LIST) |=> busy, "command not taken")
  // Results of a listing come in consecutive cycles until the last one.
  `DEQ_ASSERT_RST(a_list_burst, clk, rst, (strobe && !last) |=> strobe, "listing burst broken")
  // No result is shown in the cycle after reset.
  `DEQ_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !strobe, "result after reset")

endmodule

// ===== test/deq_checker.sv =====
// Checker for the double-ended queue: predicts every result and compares it.
`timescale 1ns / 100ps

module deq_checker #(
  parameter int DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [2:0]                        action,
  input  logic signed [deq_pkg::DATA_W-1:0] value,
  input  logic                              strobe,
  input  logic signed [deq_pkg::DATA_W-1:0] value_res,
  input  logic [1:0]                        status,
  input  logic                              last,
  output int                                fail_count,
  output int                                pending,
  output int                                results_checked,
  output int                                full_hits,
  output int                                underflow_hits
);

  import deq_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] word;
    status_t                  code;
    logic                     is_last;
  } deq_result_t;

  // Results still owed by the block, oldest first.
  deq_result_t expected_results[$];

  // Shadow copy of the queue contents.
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int shadow_front;
  int shadow_count;

  task automatic owe_result(input logic signed [DATA_W-1:0] word, input status_t code,
                            input logic is_last);
    deq_result_t r;
    r.word    = word;
    r.code    = code;
    r.is_last = is_last;
    expected_results.push_back(r);
  endtask

  // Applies one command to the shadow queue and records the results it owes.
  task automatic apply_command(input logic [2:0] act, input logic signed [DATA_W-1:0] word);
    int slot;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (shadow_count >= DEPTH) begin
          owe_result('0, ST_FULL, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_ring[shadow_front] = word;
          end else begin
            shadow_ring[(shadow_front + shadow_count) % DEPTH] = word;
          end
          shadow_count++;
          owe_result('0, ST_OK, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (shadow_count == 0) begin
          owe_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            owe_result(shadow_ring[shadow_front], ST_OK, 1'b1);
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            slot = (shadow_front + shadow_count - 1) % DEPTH;
            owe_result(shadow_ring[slot], ST_OK, 1'b1);
          end
          shadow_count--;
        end
      end
      ACT_LIST: begin
        if (shadow_count == 0) begin
          owe_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++)
            owe_result(shadow_ring[(shadow_front + i) % DEPTH], ST_OK,
                       i == shadow_count - 1);
        end
      end
      default: begin
        // Unused codes are dropped by the block without a result.
      end
    endcase
  endtask

  // Results are checked before the command of the same edge is applied, since a
  // command's results never appear in the cycle of its own transfer.
  always @(posedge clk) begin
    deq_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_front    = 0;
      shadow_count    = 0;
      fail_count      = 0;
      results_checked = 0;
      full_hits       = 0;
      underflow_hits  = 0;
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with none owed: value_res %0d, status %0d, last %0b",
                 value_res, status, last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (value_res !== want.word) begin
            $error("value_res: expected %0d, actual %0d", want.word, value_res);
            fail_count++;
          end
          if (status !== want.code) begin
            $error("status: expected %0d, actual %0d", want.code, status);
            fail_count++;
          end
          if (last !== want.is_last) begin
            $error("last: expected %0b, actual %0b", want.is_last, last);
            fail_count++;
          end
          results_checked++;
          if (want.code == ST_FULL) full_hits++;
          if (want.code == ST_UNDERFLOW) underflow_hits++;
        end
      end
      if (start && !busy) apply_command(action, value);
    end
    pending <= expected_results.size();
  end

endmodule

// ===== test/double_ended_queue_tb.sv =====
// Testbench top for the double-ended queue: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module double_ended_queue_tb;

  import deq_pkg::*;

  localparam int QUEUE_DEPTH = 32;
  localparam int RANDOM_COMMANDS = 355;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [2:0]               action = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic signed [DATA_W-1:0] value_res;
  logic [1:0]               status;
  logic                     last;

  int fail_count;
  int pending;
  int results_checked;
  int full_hits;
  int underflow_hits;
  int commands_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  double_ended_queue #(.DEPTH(QUEUE_DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .value    (value),
    .strobe   (strobe),
    .value_res(value_res),
    .status   (status),
    .last     (last)
  );

  deq_checker #(.DEPTH(QUEUE_DEPTH)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .value          (value),
    .strobe         (strobe),
    .value_res      (value_res),
    .status         (status),
    .last           (last),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked),
    .full_hits      (full_hits),
    .underflow_hits (underflow_hits)
  );

  // Watchdog: ends the run if neither a command nor a result transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Sends one command, opening a new burst after a random gap when the last one has run out.
  task automatic send_command(input logic [2:0] act, input logic signed [DATA_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start  <= 1'b1;
    action <= act;
    value  <= word;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  // Holds off new commands until every owed result has been seen.
  task automatic wait_for_results;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Push data: mostly random words, with the extremes mixed in.
  function automatic logic signed [DATA_W-1:0] pick_word;
    case ($urandom_range(0, 9))
      0: pick_word = {1'b1, {(DATA_W-1){1'b0}}};
      1: pick_word = {1'b0, {(DATA_W-1){1'b1}}};
      2: pick_word = '0;
      3: pick_word = '1;
      default: pick_word = $urandom;
    endcase
  endfunction

  initial begin
    mix_t       mix;
    int         seg;
    int         seg_len;
    int         counted;
    int         roll;
    int         push_pct;
    logic [2:0] act;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-queue errors, extreme words, wrap of the front index,
    // unused codes and draining back to empty.
    send_command(ACT_POP_FRONT, 32'sd0);
    send_command(ACT_POP_REAR, 32'sd0);
    send_command(ACT_LIST, 32'sd0);
    send_command(ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_command(ACT_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
    send_command(ACT_PUSH_FRONT, -32'sd1);
    send_command(ACT_PUSH_REAR, 32'sd0);
    send_command(ACT_LIST, 32'sd0);
    send_command(ACT_POP_FRONT, 32'sd0);
    send_command(ACT_POP_REAR, 32'sd0);
    for (int c = ACT_UNUSED_LO; c <= ACT_UNUSED_HI; c++)
      send_command(3'(c), $urandom);
    send_command(ACT_PUSH_FRONT, 32'h5555_5555);
    send_command(ACT_PUSH_REAR, 32'hAAAA_AAAA);
    send_command(ACT_POP_REAR, 32'sd0);
    send_command(ACT_POP_REAR, 32'sd0);
    send_command(ACT_POP_FRONT, 32'sd0);
    send_command(ACT_POP_FRONT, 32'sd0);
    send_command(ACT_POP_REAR, 32'sd0);
    send_command(ACT_LIST, 32'sd0);

    // Random part in segments: the first fills the queue past full, the second
    // drains it past empty, the rest pick a random mix.
    seg = 0;
    counted = 0;
    while (counted < RANDOM_COMMANDS) begin
      if (seg == 0) mix = MIX_FILL;
      else if (seg == 1) mix = MIX_DRAIN;
      else mix = mix_t'($urandom_range(0, 2));
      seg_len = (seg < 2) ? 70 : $urandom_range(20, 60);
      push_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
      for (int k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end else begin
          counted++;
          if (roll < 14) act = ACT_LIST;
          else if ($urandom_range(0, 99) < push_pct)
            act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
          else
            act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        end
        send_command(act, pick_word());
      end
      // Let the block run dry once in the middle of the run.
      if (seg == 2) wait_for_results();
      seg++;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands; checked %0d results, %0d full pushes, %0d empty pops.",
             commands_sent, results_checked, full_hits, underflow_hits);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
